// ----- rtl/lidar_ray_box_caster_unit_assert.svh -----
// Assertion macros for the lidar ray-box caster.
// Used by the checker; needs clk and rst_n in scope.
`ifndef LIDAR_RAY_BOX_CASTER_UNIT_ASSERT_SVH
`define LIDAR_RAY_BOX_CASTER_UNIT_ASSERT_SVH

// same-cycle implication
`define LRBC_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lrbc check failed");

// next-cycle implication
`define LRBC_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lrbc check failed");

`endif

// ----- rtl/lrbc_pkg.sv -----
// Package for the lidar ray-box caster: sizes, codes, box record, CORDIC table.
// No dependencies.
`default_nettype none

package lrbc_pkg;

    localparam int TABLE_ENTRIES = 16;
    localparam int MAX_BEAMS     = 64;
    localparam int TIDX_W        = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int BEAM_IDX_W    = 6;
    localparam int BEAM_CNT_W    = 7;

    localparam int DIV_NUM_W = 48;
    localparam int DIV_DEN_W = 16;
    localparam int T_W       = 42;

    localparam logic [2:0] CFG_BMIN_X = 3'd0;
    localparam logic [2:0] CFG_BMIN_Y = 3'd1;
    localparam logic [2:0] CFG_BMAX_X = 3'd2;
    localparam logic [2:0] CFG_BMAX_Y = 3'd3;
    localparam logic [2:0] CFG_EXEMPT = 3'd4;

    localparam logic [1:0] MODE_WRITE       = 2'd0;
    localparam logic [1:0] MODE_CAST_STATIC = 2'd1;
    localparam logic [1:0] MODE_CAST_ALL    = 2'd2;

    localparam logic [1:0] KIND_STATIC  = 2'd1;
    localparam logic [1:0] KIND_PERCEPT = 2'd2;

    localparam logic signed [DIV_NUM_W-1:0] QUOT_SAT = 48'sd1099511627776;
    localparam logic signed [33:0] CORDIC_GAIN_INIT = 34'sd652032874;

    typedef struct packed {
        logic signed [31:0] lx;
        logic signed [31:0] ly;
        logic signed [31:0] ux;
        logic signed [31:0] uy;
    } box_t;

    function automatic logic [31:0] atan_turn(input logic [3:0] idx);
        logic [31:0] v;
        case (idx)
            4'd0:    v = 32'h20000000;
            4'd1:    v = 32'h12E4051E;
            4'd2:    v = 32'h09FB385B;
            4'd3:    v = 32'h051111D4;
            4'd4:    v = 32'h028B0D43;
            4'd5:    v = 32'h0145D7E1;
            4'd6:    v = 32'h00A2F61E;
            4'd7:    v = 32'h00517C55;
            4'd8:    v = 32'h0028BE53;
            4'd9:    v = 32'h00145F2F;
            4'd10:   v = 32'h000A2F98;
            4'd11:   v = 32'h000517CC;
            4'd12:   v = 32'h00028BE6;
            4'd13:   v = 32'h000145F3;
            4'd14:   v = 32'h0000A2FA;
            default: v = 32'h0000517D;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/lrbc_box_mem.sv -----
// Box coordinate table: synchronous RAM, one write and one registered read port.
// Depends on lrbc_pkg.
`default_nettype none

module lrbc_box_mem (
    input  wire logic                        clk,
    input  wire logic                        we,
    input  wire logic [lrbc_pkg::TIDX_W-1:0] waddr,
    input  wire lrbc_pkg::box_t              wdata,
    input  wire logic [lrbc_pkg::TIDX_W-1:0] raddr,
    output lrbc_pkg::box_t                   rdata
);

    lrbc_pkg::box_t mem [lrbc_pkg::TABLE_ENTRIES];
    lrbc_pkg::box_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ----- rtl/lrbc_div.sv -----
// Serial signed divider, one quotient bit per cycle, truncating toward zero.
// Depends on lrbc_pkg.
`default_nettype none

module lrbc_div (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  start,
    input  wire logic signed [lrbc_pkg::DIV_NUM_W-1:0] num,
    input  wire logic signed [lrbc_pkg::DIV_DEN_W-1:0] den,
    output logic                                       done,
    output logic signed [lrbc_pkg::DIV_NUM_W-1:0]      quot
);

    localparam int NW = lrbc_pkg::DIV_NUM_W;
    localparam int DW = lrbc_pkg::DIV_DEN_W;
    localparam int CW = $clog2(NW);

    logic          run_reg;
    logic          done_reg;
    logic [CW-1:0] cnt_reg;
    logic [NW-1:0] q_reg;
    logic [DW-1:0] rem_reg;
    logic [DW-1:0] dmag_reg;
    logic          neg_reg;

    logic [DW:0]   trial;
    logic          fits;

    assign trial = {rem_reg, q_reg[NW-1]};
    assign fits  = trial >= {1'b0, dmag_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                run_reg <= 1'b1;
                cnt_reg <= CW'(NW - 1);
            end
            else if (run_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            q_reg    <= num[NW-1] ? NW'(-num) : NW'(num);
            dmag_reg <= den[DW-1] ? DW'(-den) : DW'(den);
            neg_reg  <= num[NW-1] ^ den[DW-1];
            rem_reg  <= '0;
        end
        else if (run_reg)
        begin
            rem_reg <= fits ? DW'(trial - {1'b0, dmag_reg}) : trial[DW-1:0];
            q_reg   <= {q_reg[NW-2:0], fits};
        end
    end

    assign done = done_reg;
    assign quot = neg_reg ? -$signed(q_reg) : $signed(q_reg);

endmodule

`default_nettype wire

// ----- rtl/lrbc_cordic.sv -----
// Iterative 16-step rotation CORDIC giving Q1.15 beam direction from a binary angle.
// Depends on lrbc_pkg (gain and arctangent table).
`default_nettype none

module lrbc_cordic (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    input  wire logic [15:0]        angle,
    output logic                    done,
    output logic signed [15:0]      dir_x,
    output logic signed [15:0]      dir_y
);

    logic               run_reg;
    logic               done_reg;
    logic [3:0]         it_reg;
    logic [1:0]         quad_reg;
    logic signed [33:0] x_reg;
    logic signed [33:0] y_reg;
    logic signed [32:0] z_reg;

    logic signed [33:0] sx;
    logic signed [33:0] sy;
    logic signed [32:0] at;
    logic signed [33:0] rx;
    logic signed [33:0] ry;
    logic signed [15:0] c;
    logic signed [15:0] s;

    assign sx = x_reg >>> it_reg;
    assign sy = y_reg >>> it_reg;
    assign at = $signed({1'b0, lrbc_pkg::atan_turn(it_reg)});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            it_reg   <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                run_reg <= 1'b1;
                it_reg  <= '0;
            end
            else if (run_reg)
            begin
                it_reg <= it_reg + 1'b1;
                if (it_reg == 4'd15)
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            x_reg    <= lrbc_pkg::CORDIC_GAIN_INIT;
            y_reg    <= '0;
            z_reg    <= $signed({3'b000, angle[13:0], 16'h0000});
            quad_reg <= angle[15:14];
        end
        else if (run_reg)
        begin
            if (!z_reg[32])
            begin
                x_reg <= x_reg - sy;
                y_reg <= y_reg + sx;
                z_reg <= z_reg - at;
            end
            else
            begin
                x_reg <= x_reg + sy;
                y_reg <= y_reg - sx;
                z_reg <= z_reg + at;
            end
        end
    end

    // round to Q1.15 and clamp to 0..32767
    always_comb
    begin
        rx = (x_reg + 34'sd16384) >>> 15;
        ry = (y_reg + 34'sd16384) >>> 15;
        if (rx < 0)
            c = '0;
        else if (rx > 34'sd32767)
            c = 16'sd32767;
        else
            c = rx[15:0];
        if (ry < 0)
            s = '0;
        else if (ry > 34'sd32767)
            s = 16'sd32767;
        else
            s = ry[15:0];
    end

    always_comb
    begin
        case (quad_reg)
            2'd0:
            begin
                dir_x = c;
                dir_y = s;
            end
            2'd1:
            begin
                dir_x = -s;
                dir_y = c;
            end
            2'd2:
            begin
                dir_x = -c;
                dir_y = -s;
            end
            default:
            begin
                dir_x = s;
                dir_y = -c;
            end
        endcase
    end

    assign done = done_reg;

endmodule

`default_nettype wire

// ----- rtl/lidar_ray_box_caster_unit.sv -----
// Lidar scan caster top level: sequencer, slab test datapath, box table, end point.
// Depends on lrbc_pkg, lrbc_box_mem, lrbc_div, lrbc_cordic.
//
//  channel   | handshake                  | payload
//  ----------+----------------------------+---------------------------------------------
//  command   | start, busy                | mode, point_x/y, far_x/y, entry_index,
//            |                            | entry_kind, heading, view_width, ray_count,
//            |                            | range_limit
//  result    | result_strobe (1 cycle)    | beam_angle, distance, end_x, end_y, hit, last
//  config    | cfg_we                     | cfg_index, cfg_data
//
// A write command leaves busy low. A cast holds busy until its last beam is out:
// per beam one angle division (skipped for a single beam) and a CORDIC run, then for
// the bounds and each slot a table read and up to four slab divisions on the single
// shared divider. Results come out one per beam, registered from the output state, and
// cannot be held off. Reset clears every slot to empty and the bounds to +-16.0.
`default_nettype none

module lidar_ray_box_caster_unit (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic [1:0]         mode,
    input  wire logic signed [31:0] point_x,
    input  wire logic signed [31:0] point_y,
    input  wire logic signed [31:0] far_x,
    input  wire logic signed [31:0] far_y,
    input  wire logic [3:0]         entry_index,
    input  wire logic [1:0]         entry_kind,
    input  wire logic [15:0]        heading,
    input  wire logic [15:0]        view_width,
    input  wire logic [6:0]         ray_count,
    input  wire logic [30:0]        range_limit,
    input  wire logic               cfg_we,
    input  wire logic [2:0]         cfg_index,
    input  wire logic [31:0]        cfg_data,
    output logic                    result_strobe,
    output logic [15:0]             beam_angle,
    output logic [30:0]             distance,
    output logic signed [31:0]      end_x,
    output logic signed [31:0]      end_y,
    output logic                    hit,
    output logic                    last
);

    localparam int TW = lrbc_pkg::T_W;
    localparam int KW = lrbc_pkg::TIDX_W;
    localparam int BW = lrbc_pkg::BEAM_IDX_W;
    localparam int CW = lrbc_pkg::BEAM_CNT_W;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_ANG   = 4'd1;
    localparam logic [3:0] S_ANGW  = 4'd2;
    localparam logic [3:0] S_CST   = 4'd3;
    localparam logic [3:0] S_CWAIT = 4'd4;
    localparam logic [3:0] S_RD    = 4'd5;
    localparam logic [3:0] S_LOAD  = 4'd6;
    localparam logic [3:0] S_AXIS  = 4'd7;
    localparam logic [3:0] S_WAIT  = 4'd8;
    localparam logic [3:0] S_EVAL  = 4'd9;
    localparam logic [3:0] S_NEXT  = 4'd10;
    localparam logic [3:0] S_MUL   = 4'd11;
    localparam logic [3:0] S_OUT   = 4'd12;

    // control
    logic [3:0]      state_reg, state_next;
    logic [BW-1:0]   i_reg;
    logic [CW-1:0]   n_reg;
    logic [KW-1:0]   k_reg;
    logic            on_wall_reg;
    logic [1:0]      ax_reg;
    logic            strobe_reg;
    logic [1:0]      kind_reg [lrbc_pkg::TABLE_ENTRIES];
    logic            walls_reg;
    logic            all_reg;
    logic            tmax_inf_reg;
    logic            hit_acc_reg;

    // configuration
    logic signed [31:0] bmin_x_reg, bmin_y_reg, bmax_x_reg, bmax_y_reg;
    logic               exempt_reg;

    // payload
    logic signed [31:0] ox_reg, oy_reg;
    logic [15:0]        heading_reg, vw_reg, ang_reg;
    logic [30:0]        mr_reg, best_reg;
    logic signed [15:0] dx_reg, dy_reg;
    lrbc_pkg::box_t     box_reg;
    logic               inside_reg;
    logic signed [TW-1:0] t1_reg, tmin_reg, tmax_reg;
    logic signed [47:0] px_reg, py_reg;
    logic [15:0]        out_ang_reg;
    logic [30:0]        out_dist_reg;
    logic signed [31:0] out_ex_reg, out_ey_reg;
    logic               out_hit_reg, out_last_reg;

    // datapath nets
    logic               accept, is_cast, mem_we;
    logic [KW-1:0]      waddr;
    lrbc_pkg::box_t     wbox, rbox, box_sel;
    logic               any_static;
    logic signed [31:0] o_sel, lo_sel, hi_sel, edge_sel;
    logic signed [15:0] d_sel;
    logic signed [32:0] diff;
    logic               in_slab;
    logic               div_start, div_done;
    logic signed [47:0] div_num, div_quot;
    logic signed [15:0] div_den;
    logic [21:0]        iv;
    logic [CW-1:0]      nm1;
    logic [15:0]        ang_base;
    logic signed [TW-1:0] tq, t_lo, t_hi, tmin_new, tmax_new, t_pick;
    logic               slot_active, inside_sel, eval_ok, last_beam;
    logic               cor_start, cor_done;
    logic signed [15:0] cor_x, cor_y;
    logic signed [48:0] sum_x, sum_y;
    logic signed [31:0] ex, ey;
    logic [CW-1:0]      n_eff;

    assign accept  = start && !busy;
    assign is_cast = (mode == lrbc_pkg::MODE_CAST_STATIC) || (mode == lrbc_pkg::MODE_CAST_ALL);
    assign mem_we  = accept && (mode == lrbc_pkg::MODE_WRITE)
                     && (int'(entry_index) < lrbc_pkg::TABLE_ENTRIES);
    assign waddr   = KW'(entry_index);
    assign wbox    = '{lx: point_x, ly: point_y, ux: far_x, uy: far_y};

    always_comb
    begin
        if (ray_count == '0)
            n_eff = CW'(1);
        else if (int'(ray_count) > lrbc_pkg::MAX_BEAMS)
            n_eff = CW'(lrbc_pkg::MAX_BEAMS);
        else
            n_eff = ray_count;
    end

    always_comb
    begin
        any_static = 1'b0;
        for (int e = 0; e < lrbc_pkg::TABLE_ENTRIES; e++)
        begin
            if (kind_reg[e] == lrbc_pkg::KIND_STATIC)
                any_static = 1'b1;
        end
    end

    lrbc_box_mem u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (waddr),
        .wdata (wbox),
        .raddr (k_reg),
        .rdata (rbox)
    );

    // slot selection and slab operands
    assign box_sel = on_wall_reg ? lrbc_pkg::box_t'{lx: bmin_x_reg, ly: bmin_y_reg,
                                                    ux: bmax_x_reg, uy: bmax_y_reg} : rbox;
    assign slot_active = on_wall_reg ? walls_reg :
                         ((kind_reg[k_reg] == lrbc_pkg::KIND_STATIC)
                          || ((kind_reg[k_reg] == lrbc_pkg::KIND_PERCEPT) && all_reg));
    assign inside_sel = (ox_reg >= box_sel.lx) && (ox_reg <= box_sel.ux)
                        && (oy_reg >= box_sel.ly) && (oy_reg <= box_sel.uy);

    assign o_sel    = ax_reg[1] ? oy_reg : ox_reg;
    assign d_sel    = ax_reg[1] ? dy_reg : dx_reg;
    assign lo_sel   = ax_reg[1] ? box_reg.ly : box_reg.lx;
    assign hi_sel   = ax_reg[1] ? box_reg.uy : box_reg.ux;
    assign edge_sel = ax_reg[0] ? hi_sel : lo_sel;
    assign diff     = {edge_sel[31], edge_sel} - {o_sel[31], o_sel};
    assign in_slab  = (o_sel >= lo_sel) && (o_sel <= hi_sel);

    // beam angle: heading - vw/2 + i*vw/(n-1)
    assign iv       = 22'(i_reg) * 22'(vw_reg);
    assign nm1      = n_reg - CW'(1);
    assign ang_base = heading_reg - {1'b0, vw_reg[15:1]};

    assign div_start = ((state_reg == S_AXIS) && (d_sel != '0))
                       || ((state_reg == S_ANG) && (n_reg != CW'(1)));
    assign div_num   = (state_reg == S_ANG) ? $signed({26'd0, iv}) : $signed({diff, 15'd0});
    assign div_den   = (state_reg == S_ANG) ? $signed(16'(nm1)) : d_sel;

    lrbc_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quot  (div_quot)
    );

    assign cor_start = (state_reg == S_CST);

    lrbc_cordic u_cordic (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cor_start),
        .angle (ang_reg),
        .done  (cor_done),
        .dir_x (cor_x),
        .dir_y (cor_y)
    );

    // quotient saturation and slab interval update
    always_comb
    begin
        if (div_quot > lrbc_pkg::QUOT_SAT)
            tq = TW'(lrbc_pkg::QUOT_SAT);
        else if (div_quot < -lrbc_pkg::QUOT_SAT)
            tq = TW'(-lrbc_pkg::QUOT_SAT);
        else
            tq = div_quot[TW-1:0];
        t_lo     = (t1_reg < tq) ? t1_reg : tq;
        t_hi     = (t1_reg < tq) ? tq : t1_reg;
        tmin_new = (t_lo > tmin_reg) ? t_lo : tmin_reg;
        tmax_new = (tmax_inf_reg || (t_hi < tmax_reg)) ? t_hi : tmax_reg;
    end

    always_comb
    begin
        t_pick  = inside_reg ? tmax_reg : tmin_reg;
        eval_ok = !(!tmax_inf_reg && (tmax_reg < 0))
                  && !(inside_reg && tmax_inf_reg)
                  && (t_pick >= 0)
                  && (t_pick <= $signed({11'd0, mr_reg}))
                  && (on_wall_reg || (t_pick < $signed({11'd0, best_reg})));
    end

    assign last_beam = ({1'b0, i_reg} + CW'(1)) == n_reg;

    // end point, products floored to Q15.16, then saturated
    always_comb
    begin
        sum_x = 49'(ox_reg) + 49'(px_reg >>> 15);
        sum_y = 49'(oy_reg) + 49'(py_reg >>> 15);
        if (sum_x > 49'sd2147483647)
            ex = 32'sh7FFFFFFF;
        else if (sum_x < -49'sd2147483648)
            ex = 32'sh80000000;
        else
            ex = sum_x[31:0];
        if (sum_y > 49'sd2147483647)
            ey = 32'sh7FFFFFFF;
        else if (sum_y < -49'sd2147483648)
            ey = 32'sh80000000;
        else
            ey = sum_y[31:0];
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
                if (accept && is_cast)
                    state_next = S_ANG;
            S_ANG:
                state_next = (n_reg == CW'(1)) ? S_CST : S_ANGW;
            S_ANGW:
                if (div_done)
                    state_next = S_CST;
            S_CST:
                state_next = S_CWAIT;
            S_CWAIT:
                if (cor_done)
                    state_next = S_RD;
            S_RD:
                state_next = S_LOAD;
            S_LOAD:
                state_next = slot_active ? S_AXIS : S_NEXT;
            S_AXIS:
                if (d_sel != '0)
                    state_next = S_WAIT;
                else if (!in_slab)
                    state_next = S_NEXT;
                else if (ax_reg[1])
                    state_next = S_EVAL;
            S_WAIT:
                if (div_done)
                begin
                    if (!ax_reg[0])
                        state_next = S_AXIS;
                    else if (tmin_new > tmax_new)
                        state_next = S_NEXT;
                    else if (ax_reg[1])
                        state_next = S_EVAL;
                    else
                        state_next = S_AXIS;
                end
            S_EVAL:
                state_next = S_NEXT;
            S_NEXT:
                if (!on_wall_reg && (k_reg == KW'(lrbc_pkg::TABLE_ENTRIES - 1)))
                    state_next = S_MUL;
                else
                    state_next = S_RD;
            S_MUL:
                state_next = S_OUT;
            S_OUT:
                state_next = last_beam ? S_IDLE : S_ANG;
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            i_reg        <= '0;
            k_reg        <= '0;
            on_wall_reg  <= 1'b0;
            ax_reg       <= '0;
            strobe_reg   <= 1'b0;
            tmax_inf_reg <= 1'b1;
            hit_acc_reg  <= 1'b0;
            bmin_x_reg   <= -32'sd1048576;
            bmin_y_reg   <= -32'sd1048576;
            bmax_x_reg   <= 32'sd1048576;
            bmax_y_reg   <= 32'sd1048576;
            exempt_reg   <= 1'b0;
            for (int e = 0; e < lrbc_pkg::TABLE_ENTRIES; e++)
                kind_reg[e] <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            strobe_reg <= (state_reg == S_OUT);
            if (cfg_we)
            begin
                case (cfg_index)
                    lrbc_pkg::CFG_BMIN_X: bmin_x_reg <= cfg_data;
                    lrbc_pkg::CFG_BMIN_Y: bmin_y_reg <= cfg_data;
                    lrbc_pkg::CFG_BMAX_X: bmax_x_reg <= cfg_data;
                    lrbc_pkg::CFG_BMAX_Y: bmax_y_reg <= cfg_data;
                    lrbc_pkg::CFG_EXEMPT: exempt_reg <= cfg_data[0];
                    default: ;
                endcase
            end
            if (mem_we)
                kind_reg[waddr] <= entry_kind;
            case (state_reg)
                S_IDLE:
                    i_reg <= '0;
                S_CWAIT:
                begin
                    on_wall_reg <= 1'b1;
                    k_reg       <= '0;
                    hit_acc_reg <= 1'b0;
                end
                S_LOAD:
                begin
                    ax_reg       <= '0;
                    tmax_inf_reg <= 1'b1;
                end
                S_AXIS:
                    if ((d_sel == '0) && in_slab)
                        ax_reg <= ax_reg + 2'd2;
                S_WAIT:
                    if (div_done)
                    begin
                        ax_reg <= ax_reg + 2'd1;
                        if (ax_reg[0])
                            tmax_inf_reg <= 1'b0;
                    end
                S_EVAL:
                    if (eval_ok)
                        hit_acc_reg <= 1'b1;
                S_NEXT:
                    if (on_wall_reg)
                    begin
                        on_wall_reg <= 1'b0;
                        k_reg       <= '0;
                    end
                    else
                        k_reg <= k_reg + 1'b1;
                S_OUT:
                    i_reg <= i_reg + 1'b1;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
                if (accept && is_cast)
                begin
                    ox_reg      <= point_x;
                    oy_reg      <= point_y;
                    heading_reg <= heading;
                    vw_reg      <= view_width;
                    n_reg       <= n_eff;
                    mr_reg      <= range_limit;
                    all_reg     <= (mode == lrbc_pkg::MODE_CAST_ALL);
                    walls_reg   <= !(exempt_reg && !any_static);
                end
            S_ANG:
                ang_reg <= ang_base;
            S_ANGW:
                if (div_done)
                    ang_reg <= ang_base + div_quot[15:0];
            S_CWAIT:
                if (cor_done)
                begin
                    dx_reg   <= cor_x;
                    dy_reg   <= cor_y;
                    best_reg <= mr_reg;
                end
            S_LOAD:
            begin
                box_reg    <= box_sel;
                inside_reg <= inside_sel;
                tmin_reg   <= '0;
            end
            S_WAIT:
                if (div_done)
                begin
                    if (!ax_reg[0])
                        t1_reg <= tq;
                    else
                    begin
                        tmin_reg <= tmin_new;
                        tmax_reg <= tmax_new;
                    end
                end
            S_EVAL:
                if (eval_ok)
                    best_reg <= t_pick[30:0];
            S_MUL:
            begin
                px_reg <= 48'(dx_reg) * $signed({17'd0, best_reg});
                py_reg <= 48'(dy_reg) * $signed({17'd0, best_reg});
            end
            S_OUT:
            begin
                out_ang_reg  <= ang_reg;
                out_dist_reg <= best_reg;
                out_ex_reg   <= ex;
                out_ey_reg   <= ey;
                out_hit_reg  <= hit_acc_reg;
                out_last_reg <= last_beam;
            end
            default: ;
        endcase
    end

    assign busy          = (state_reg != S_IDLE);
    assign result_strobe = strobe_reg;
    assign beam_angle    = out_ang_reg;
    assign distance      = out_dist_reg;
    assign end_x         = out_ex_reg;
    assign end_y         = out_ey_reg;
    assign hit           = out_hit_reg;
    assign last          = out_last_reg;

endmodule

`default_nettype wire

// ----- rtl/lrbc_checker.sv -----
// Port-level checker for lidar_ray_box_caster_unit, bound to the top level.
// Depends on lidar_ray_box_caster_unit_assert.svh.
`default_nettype none

`include "lidar_ray_box_caster_unit_assert.svh"

module lrbc_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       busy,
    input wire logic       result_strobe,
    input wire logic       last
);

    // a cast stays busy between its beams
    `LRBC_ASSERT_IMP(a_mid_busy, result_strobe && !last, busy)
    // final beam transfer releases the block
    `LRBC_ASSERT_IMP(a_last_idle, result_strobe && last, !busy)
    // busy only drops with the final beam
    `LRBC_ASSERT_IMP(a_fell_last, $fell(busy), result_strobe && last)
    // no result without a cast in flight
    `LRBC_ASSERT_NXT(a_no_spur, !busy, !result_strobe)

endmodule

bind lidar_ray_box_caster_unit lrbc_checker u_lrbc_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .busy          (busy),
    .result_strobe (result_strobe),
    .last          (last)
);

`default_nettype wire
